// ----- design/rgbd_pkg.sv -----
package rgbd_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 16;
    localparam int SAMPLE_W  = 8;
    localparam int LEVEL_W   = 8;
    localparam int ENT_W     = 16;
    localparam int ERR_W     = 12;
    localparam int LANES     = 3;
    localparam int STORE_W   = LANES * ENT_W;

    localparam int BITS_W    = 4;
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 16;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [BITS_W-1:0]   BITS_RESET   = 4'd1;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;
    localparam logic [BITS_W-1:0]   BITS_MAX     = 4'd8;

    // Full scale is 255 on a grid of sixteenths.
    localparam int HALF_SCALE  = 4080;
    localparam int TWICE_SCALE = 2 * HALF_SCALE;
    // ceil(2^36 / 8160): exact floor division for dividends below 2^22.
    localparam logic [23:0] RECIP_SCALE = 24'd8421505;
    localparam int RECIP_SCALE_SHIFT    = 36;
    localparam int RECIP_N_SHIFT        = 32;

    typedef enum logic [1:0] {
        REG_BITS   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [BITS_W-1:0]   bits;
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
    } cfg_t;

    typedef struct packed {
        logic ld_pix;
        logic ld_x;
        logic use_below;
        logic ld_left;
        logic ld_t1;
        logic ld_lvl;
        logic ld_t2;
        logic ld_recon;
        logic ld_err;
        logic upd_carry;
        logic clr_carry;
    } lane_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_MUL1,
        ST_DIV1,
        ST_MUL2,
        ST_DIV2,
        ST_ERR,
        ST_DONE
    } state_t;

    // ceil(2^31 / n) for n = 2^b - 1, so that a product shifted right by 32
    // gives floor(t / (2n)) exactly for t below 2^23.
    function automatic logic [31:0] recip_for_bits(input logic [BITS_W-1:0] b);
        logic [31:0] r;
        begin
            case (b)
                4'd1:    r = 32'd2147483648;
                4'd2:    r = 32'd715827883;
                4'd3:    r = 32'd306783379;
                4'd4:    r = 32'd143165577;
                4'd5:    r = 32'd69273667;
                4'd6:    r = 32'd34087043;
                4'd7:    r = 32'd16909321;
                default: r = 32'd8421505;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- design/rgb_error_diffusion_dither.sv -----
// Channel   Direction  Handshake                 Contents
// s_axis    in         s_tvalid / s_tready       s_tdata: red_in, green_in, blue_in
// m_axis    out        m_tvalid / m_tready       m_tdata: levels, m_tlast: row_end,
//                                                m_tuser: frame_end
// apb       in         psel / penable / pready   bits_per_channel, image_width,
//                                                image_height at 0x0, 0x4, 0x8
//
// Between acceptance and the output register the three channels run side by
// side through two multiply-and-scale steps, with one read and one write port
// on the error store. The next item is accepted in the cycle after the
// previous result has moved into the output register, so no item is taken
// before the last is through, and a stalled consumer holds only one finished
// item there.
// Reset returns the registers to 1, 640 and 480 and the pixel position to the
// top left; the error store is not cleared, as row zero never reads it.
module rgb_error_diffusion_dither (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // red_in, green_in, blue_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // red_level, green_level, blue_level
    output logic                          m_tlast,   // row_end
    output logic                          m_tuser,   // frame_end
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rgbd_pkg::PADDR_W-1:0]  paddr,
    input  logic [rgbd_pkg::PDATA_W-1:0]  pwdata,
    output logic [rgbd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import rgbd_pkg::*;

    cfg_t                 cfg;
    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    col_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [ADDR_W-1:0]    pix_col_reg;
    logic                 last_col_reg;
    logic                 last_row_reg;
    logic                 row_nz_reg;
    logic                 m_tvalid_reg;
    logic [23:0]          m_tdata_reg;
    logic                 m_tlast_reg;
    logic                 m_tuser_reg;

    logic [BITS_W-1:0]    bits_eff;
    logic [WIDTH_W-1:0]   width_eff;
    logic [HEIGHT_W-1:0]  height_eff;
    logic [LEVEL_W-1:0]   n_levels;
    logic [31:0]          recip_n;
    logic                 last_col;
    logic                 last_row;
    logic                 accept;
    logic                 push;

    lane_ctl_t            ctl;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [STORE_W-1:0]   wr_data;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [STORE_W-1:0]   rd_data;
    logic [STORE_W-1:0]   cur_entries;
    logic [STORE_W-1:0]   left_entries;
    logic [23:0]          levels;

    rgbd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rgbd_err_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        rgbd_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .sample     (s_tdata[g*SAMPLE_W +: SAMPLE_W]),
            .entry      (rd_data[g*ENT_W +: ENT_W]),
            .n_levels   (n_levels),
            .recip_n    (recip_n),
            .level      (levels[g*LEVEL_W +: LEVEL_W]),
            .cur_entry  (cur_entries[g*ENT_W +: ENT_W]),
            .left_entry (left_entries[g*ENT_W +: ENT_W])
        );
    end

    // Out-of-range register values are folded onto the nearest legal one.
    always_comb
    begin
        if (cfg.bits == '0)
        begin
            bits_eff = BITS_W'(1);
        end
        else if (cfg.bits > BITS_MAX)
        begin
            bits_eff = BITS_MAX;
        end
        else
        begin
            bits_eff = cfg.bits;
        end

        if (cfg.width == '0)
        begin
            width_eff = WIDTH_W'(1);
        end
        else if (cfg.width > WIDTH_W'(MAX_WIDTH))
        begin
            width_eff = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = cfg.width;
        end

        height_eff = (cfg.height == '0) ? HEIGHT_W'(1) : cfg.height;
    end

    assign n_levels = LEVEL_W'((9'd1 << bits_eff) - 9'd1);
    assign recip_n  = recip_for_bits(bits_eff);

    // A column or row at or past the configured end closes the row or frame,
    // which keeps the counters sane if the geometry changes mid-frame.
    assign last_col = (WIDTH_W'(col_reg) + WIDTH_W'(1)) >= width_eff;
    assign last_row = ((ROW_W + 1)'(row_reg) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(height_eff);

    assign accept   = s_tvalid && s_tready;
    assign push     = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        ctl           = '0;
        ctl.use_below = row_nz_reg;
        ctl.clr_carry = last_col_reg;
        rd_en         = 1'b0;
        rd_addr       = col_reg;
        wr_en         = 1'b0;
        wr_addr       = pix_col_reg;
        wr_data       = cur_entries;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                ctl.ld_pix = s_tvalid;
                rd_en      = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                // Entry below is on the read port; fetch the lower-left entry.
                ctl.ld_x   = 1'b1;
                rd_en      = (pix_col_reg != '0);
                rd_addr    = pix_col_reg - ADDR_W'(1);
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                ctl.ld_left = 1'b1;
                ctl.ld_t1   = 1'b1;
                state_next  = ST_DIV1;
            end
            ST_DIV1:
            begin
                ctl.ld_lvl = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                ctl.ld_t2  = 1'b1;
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                ctl.ld_recon = 1'b1;
                state_next   = ST_ERR;
            end
            ST_ERR:
            begin
                ctl.ld_err = 1'b1;
                wr_en      = !last_row_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // The lower-left write repeats harmlessly while the output waits.
                wr_en         = !last_row_reg && (pix_col_reg != '0);
                wr_addr       = pix_col_reg - ADDR_W'(1);
                wr_data       = left_entries;
                ctl.upd_carry = push;
                if (push)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            col_reg      <= '0;
            row_reg      <= '0;
            pix_col_reg  <= '0;
            last_col_reg <= 1'b0;
            last_row_reg <= 1'b0;
            row_nz_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                pix_col_reg  <= col_reg;
                last_col_reg <= last_col;
                last_row_reg <= last_row;
                row_nz_reg   <= (row_reg != '0);
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + ADDR_W'(1);
                end
            end
            if (push)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            m_tdata_reg <= levels;
            m_tlast_reg <= last_col_reg;
            m_tuser_reg <= last_col_reg && last_row_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- design/rgbd_cfg.sv -----
module rgbd_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rgbd_pkg::PADDR_W-1:0]  paddr,
    input  logic [rgbd_pkg::PDATA_W-1:0]  pwdata,
    output logic [rgbd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output rgbd_pkg::cfg_t                cfg
);
    import rgbd_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr     = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bits   <= BITS_RESET;
            cfg_reg.width  <= WIDTH_RESET;
            cfg_reg.height <= HEIGHT_RESET;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_BITS:   cfg_reg.bits   <= pwdata[BITS_W-1:0];
                REG_WIDTH:  cfg_reg.width  <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT: cfg_reg.height <= pwdata[HEIGHT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_BITS:   prdata = PDATA_W'(cfg_reg.bits);
            REG_WIDTH:  prdata = PDATA_W'(cfg_reg.width);
            REG_HEIGHT: prdata = PDATA_W'(cfg_reg.height);
            default:    prdata = '0;
        endcase
    end

endmodule

// ----- design/rgbd_err_store.sv -----
module rgbd_err_store (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [rgbd_pkg::ADDR_W-1:0]   wr_addr,
    input  logic [rgbd_pkg::STORE_W-1:0]  wr_data,
    input  logic                          rd_en,
    input  logic [rgbd_pkg::ADDR_W-1:0]   rd_addr,
    output logic [rgbd_pkg::STORE_W-1:0]  rd_data
);
    import rgbd_pkg::*;

    // One entry per column: the three channel errors owed to the next row.
    logic [STORE_W-1:0] mem [MAX_WIDTH];
    logic [STORE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/rgbd_lane.sv -----
module rgbd_lane (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rgbd_pkg::lane_ctl_t            ctl,
    input  logic [rgbd_pkg::SAMPLE_W-1:0]  sample,
    input  logic [rgbd_pkg::ENT_W-1:0]     entry,
    input  logic [rgbd_pkg::LEVEL_W-1:0]   n_levels,
    input  logic [31:0]                    recip_n,
    output logic [rgbd_pkg::LEVEL_W-1:0]   level,
    output logic [rgbd_pkg::ENT_W-1:0]     cur_entry,
    output logic [rgbd_pkg::ENT_W-1:0]     left_entry
);
    import rgbd_pkg::*;

    logic [SAMPLE_W-1:0]      sample_reg;
    logic signed [ERR_W-1:0]  carry_reg;
    logic signed [13:0]       x_reg;
    logic [ENT_W-1:0]         left_reg;
    logic [21:0]              t1_reg;
    logic [9:0]               lvl_mag_reg;
    logic                     lvl_neg_reg;
    logic [22:0]              t2_reg;
    logic signed [14:0]       recon_reg;
    logic signed [ERR_W-1:0]  e_reg;

    logic signed [17:0]       below;
    logic signed [17:0]       acc;
    logic [17:0]              acc_mag;
    logic [12:0]              rnd_mag;
    logic signed [13:0]       rnd;
    logic signed [13:0]       x_next;
    logic [12:0]              x_mag;
    logic [20:0]              prod1;
    logic [45:0]              prod2;
    logic [54:0]              prod3;
    logic [13:0]              recon_mag;
    logic signed [14:0]       e_full;
    logic signed [ERR_W-1:0]  e_now;
    logic signed [ENT_W-1:0]  e_now16;
    logic signed [ENT_W-1:0]  e_reg16;

    // Accumulated error: seven times the left neighbour's error plus the
    // entry left by the row above, then rounded from 1/256 to 1/16 units.
    assign below   = ctl.use_below ? 18'(signed'(entry)) : 18'sd0;
    assign acc     = 18'(carry_reg) * 18'sd7 + below;
    assign acc_mag = acc[17] ? 18'(-acc) : 18'(acc);
    assign rnd_mag = 13'((acc_mag + 18'd8) >> 4);
    assign rnd     = acc[17] ? -$signed({1'b0, rnd_mag}) : $signed({1'b0, rnd_mag});
    assign x_next  = $signed({2'b00, sample_reg, 4'b0000}) + rnd;

    assign x_mag   = x_reg[13] ? 13'(-x_reg) : 13'(x_reg);
    assign prod1   = 21'(x_mag) * 21'(n_levels);
    assign prod2   = 46'(t1_reg) * 46'(RECIP_SCALE);
    assign prod3   = 55'(t2_reg) * 55'(recip_n);
    assign recon_mag = prod3[RECIP_N_SHIFT +: 14];

    assign e_full  = 15'(x_reg) - recon_reg;
    assign e_now   = e_full[ERR_W-1:0];
    assign e_now16 = ENT_W'(e_now);
    assign e_reg16 = ENT_W'(e_reg);

    // Five sixteenths below plus one sixteenth from the left neighbour.
    assign cur_entry  = (e_now16 <<< 2) + e_now16 + ENT_W'(carry_reg);
    // Three sixteenths to the lower left, added to what is already stored.
    assign left_entry = left_reg + (e_reg16 <<< 1) + e_reg16;

    always_comb
    begin
        if (lvl_neg_reg)
        begin
            level = '0;
        end
        else if (lvl_mag_reg > 10'(n_levels))
        begin
            level = n_levels;
        end
        else
        begin
            level = lvl_mag_reg[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
        end
        else if (ctl.upd_carry)
        begin
            carry_reg <= ctl.clr_carry ? '0 : e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_pix)
        begin
            sample_reg <= sample;
        end
        if (ctl.ld_x)
        begin
            x_reg <= x_next;
        end
        if (ctl.ld_left)
        begin
            left_reg <= entry;
        end
        if (ctl.ld_t1)
        begin
            t1_reg <= {prod1, 1'b0} + 22'(HALF_SCALE);
        end
        if (ctl.ld_lvl)
        begin
            lvl_mag_reg <= prod2[RECIP_SCALE_SHIFT +: 10];
            lvl_neg_reg <= x_reg[13] && (prod2[RECIP_SCALE_SHIFT +: 10] != 10'd0);
        end
        if (ctl.ld_t2)
        begin
            t2_reg <= 23'(lvl_mag_reg) * 23'(TWICE_SCALE) + 23'(n_levels);
        end
        if (ctl.ld_recon)
        begin
            recon_reg <= lvl_neg_reg ? -$signed({1'b0, recon_mag})
                                     : $signed({1'b0, recon_mag});
        end
        if (ctl.ld_err)
        begin
            e_reg <= e_now;
        end
    end

endmodule
